// ----- src/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, codes, prompt text and the job descriptor for the
// terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 5;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 6;
    localparam int ACT_W  = 3;
    localparam int STEP_W = 3;

    localparam logic [OP_W-1:0] OP_CHAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISTURB = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_EMPTY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PRINT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_XOFF   = 8'h13;
    localparam logic [CHAR_W-1:0] CH_XON    = 8'h11;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_K      = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;

    localparam logic [STEP_W-1:0] PROMPT_LAST = 3'd5;

    typedef struct packed {
        logic              redraw;
        logic [ACT_W-1:0]  act;
        logic              sel;
        logic [LEN_W-1:0]  fill;
        logic [CHAR_W-1:0] chr;
        logic [IDX_W-1:0]  rd_idx;
        logic              rd_empty;
    } job_t;

    // "CLI > "
    function automatic logic [CHAR_W-1:0] prompt_char(input logic [STEP_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h43;
            3'd1:    ch = 8'h4C;
            3'd2:    ch = 8'h49;
            3'd3:    ch = CH_SPACE;
            3'd4:    ch = 8'h3E;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/tle_in_if.sv -----
// ----------------------------------------------------------------------------
// tle_in_if
// Input word channel: operation, received byte and read index.
// ----------------------------------------------------------------------------
interface tle_in_if;
    import tle_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, output operation, output char_in, output read_index,
                    input ready);
    modport sink   (input valid, input operation, input char_in, input read_index,
                    output ready);
endinterface

// ----- src/tle_out_if.sv -----
// ----------------------------------------------------------------------------
// tle_out_if
// Result word channel: echo bytes, ready notices and read data.
// ----------------------------------------------------------------------------
interface tle_out_if;
    import tle_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] byte_out;
    logic [LEN_W-1:0]  line_length;
    logic              trace_on;
    logic              last;

    modport source (output valid, output kind, output byte_out, output line_length,
                    output trace_on, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input line_length,
                    input trace_on, input last, output ready);
endinterface

// ----- src/terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// terminal_line_editor
// Command line editor over two line buffers: edits, echoes, redraws the
// prompt and pending text, commits lines and serves reads of the ready line.
//
//   channel  dir  words
//   item     in   operation, char_in, read_index
//   result   out  kind, byte_out, line_length, trace_on, last
//
// One item at a time. An item is accepted, then its result words follow: up to
// 1 + 6 + (LINE_DEPTH-1) redraw words and up to 7 action words, paced by the
// result sequencer. Line bytes are read from the line store one per cycle while
// the result channel does not stall, with the address presented the cycle before
// the byte is used. Items with no result leave item ready high. Reset is
// asynchronous; the line store is not cleared. Result stalls hold the sequencer;
// item ready is low until the last word is registered.
module terminal_line_editor #(
    parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tle_in_if.sink    item,
    tle_out_if.source result
);
    import tle_pkg::*;

    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(2 * LINE_DEPTH);

    logic [FW-1:0] fill_act_reg, fill_act_next;
    logic [FW-1:0] fill_rdy_reg, fill_rdy_next;
    logic          active_reg, active_next;
    logic          ready_valid_reg, ready_valid_next;
    logic          redraw_reg, redraw_next;
    logic          trace_reg, trace_next;

    logic              fire;
    logic              seq_idle;
    logic              forced;
    logic              do_redraw;
    logic [CHAR_W-1:0] ce;
    logic [ACT_W-1:0]  act;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_data;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     seq_rd_addr;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;
    job_t              job;

    assign item.ready = seq_idle;
    assign fire       = item.valid && item.ready;

    assign forced    = fill_act_reg >= FW'(LINE_DEPTH - 1);
    assign ce        = forced ? CH_CR : item.char_in;
    assign do_redraw = (item.operation == OP_CHAR) && redraw_reg && (item.char_in != CH_CR);

    always_comb
    begin
        fill_act_next    = fill_act_reg;
        fill_rdy_next    = fill_rdy_reg;
        active_next      = active_reg;
        ready_valid_next = ready_valid_reg;
        redraw_next      = redraw_reg;
        trace_next       = trace_reg;
        act              = ACT_NONE;
        wr_en            = 1'b0;
        wr_data          = ce;
        case (item.operation)
            OP_CHAR:
            begin
                redraw_next = redraw_reg && !do_redraw;
                if (ce == CH_CR)
                begin
                    if (fill_act_reg != '0)
                    begin
                        act              = ACT_COMMIT;
                        wr_en            = 1'b1;
                        wr_data          = CH_LF;
                        fill_rdy_next    = fill_act_reg + FW'(1);
                        fill_act_next    = '0;
                        active_next      = !active_reg;
                        ready_valid_next = 1'b1;
                    end
                    else
                    begin
                        act = ACT_EMPTY;
                    end
                end
                else if (ce == CH_ESC)
                begin
                    act = ACT_NONE;
                end
                else if (ce == CH_XOFF)
                begin
                    trace_next = 1'b0;
                end
                else if (ce == CH_XON)
                begin
                    trace_next = 1'b1;
                end
                else if ((ce == CH_BS) || (ce == CH_DEL))
                begin
                    act = ACT_ERASE;
                    if (fill_act_reg != '0)
                    begin
                        fill_act_next = fill_act_reg - FW'(1);
                    end
                end
                else if ((ce < CH_SPACE) || (ce > CH_TILDE))
                begin
                    act = ACT_NONE;
                end
                else
                begin
                    act           = ACT_PRINT;
                    wr_en         = 1'b1;
                    fill_act_next = fill_act_reg + FW'(1);
                end
            end
            OP_DISTURB:
            begin
                redraw_next = 1'b1;
            end
            OP_READ:
            begin
                act = ACT_READ;
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase
    end

    assign job.redraw   = do_redraw;
    assign job.act      = act;
    assign job.sel      = (item.operation == OP_READ) ? !active_reg : active_reg;
    assign job.fill     = LEN_W'(fill_act_reg);
    assign job.chr      = ce;
    assign job.rd_idx   = item.read_index;
    assign job.rd_empty = !ready_valid_reg
                          || (LEN_W'(item.read_index) >= LEN_W'(fill_rdy_reg));

    assign wr_addr = (active_reg ? AW'(LINE_DEPTH) : '0) + AW'(fill_act_reg);
    assign rd_addr = fire ? ((active_reg ? '0 : AW'(LINE_DEPTH)) + AW'(item.read_index))
                          : seq_rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_act_reg    <= '0;
            fill_rdy_reg    <= '0;
            active_reg      <= 1'b0;
            ready_valid_reg <= 1'b0;
            redraw_reg      <= 1'b1;
            trace_reg       <= 1'b1;
        end
        else if (fire)
        begin
            fill_act_reg    <= fill_act_next;
            fill_rdy_reg    <= fill_rdy_next;
            active_reg      <= active_next;
            ready_valid_reg <= ready_valid_next;
            redraw_reg      <= redraw_next;
            trace_reg       <= trace_next;
        end
    end

    tle_line_mem #(
        .DEPTH (2 * LINE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (fire && wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tle_seq #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (fire),
        .job     (job),
        .trace   (trace_reg),
        .idle    (seq_idle),
        .rd_addr (seq_rd_addr),
        .rd_data (rd_data),
        .result  (result)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_act_reg <= FW'(LINE_DEPTH - 1))
        else $error("active fill beyond line depth");

    a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
        ready_valid_reg |-> (fill_rdy_reg >= FW'(2)))
        else $error("ready line shorter than one byte plus newline");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (act == ACT_COMMIT)) |=>
            (ready_valid_reg && (fill_act_reg == '0) && (active_reg != $past(active_reg))))
        else $error("commit did not swap buffers");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ((act != ACT_NONE) || do_redraw)) |=> !item.ready)
        else $error("item taken while results pending");

endmodule

// ----- src/tle_line_mem.sv -----
// ----------------------------------------------------------------------------
// tle_line_mem
// Line store for both buffers: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tle_line_mem #(
    parameter int DEPTH = 2 * tle_pkg::LINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [tle_pkg::CHAR_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [tle_pkg::CHAR_W-1:0] rd_data
);
    import tle_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/tle_seq.sv -----
// ----------------------------------------------------------------------------
// tle_seq
// Result sequencer: walks the redraw (CR, prompt, pending bytes) and the
// action words of one job, reading line bytes from the store, into an
// output register.
// ----------------------------------------------------------------------------
module tle_seq #(
    parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(2 * LINE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tle_pkg::job_t              job,
    input  logic                       trace,
    output logic                       idle,
    output logic [AW-1:0]              rd_addr,
    input  logic [tle_pkg::CHAR_W-1:0] rd_data,
    tle_out_if.source                  result
);
    import tle_pkg::*;

    localparam int IW = $clog2(LINE_DEPTH);

    localparam logic [2:0] SQ_IDLE   = 3'd0;
    localparam logic [2:0] SQ_RCR    = 3'd1;
    localparam logic [2:0] SQ_PROMPT = 3'd2;
    localparam logic [2:0] SQ_LINE   = 3'd3;
    localparam logic [2:0] SQ_ACT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IW-1:0]     idx_reg, idx_next;
    job_t              job_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              trace_reg;
    logic              last_reg;

    logic              emit;
    logic              redraw_end;
    logic [2:0]        act_entry;
    logic [KIND_W-1:0] cur_kind;
    logic [CHAR_W-1:0] cur_byte;
    logic [LEN_W-1:0]  cur_len;
    logic              cur_last;
    logic [AW-1:0]     rd_base;

    assign idle = (state_reg == SQ_IDLE);
    assign emit = !idle && (!out_valid_reg || result.ready);
    assign act_entry = (job_reg.act == ACT_NONE) ? SQ_IDLE : SQ_ACT;

    always_comb
    begin
        cur_kind   = KIND_ECHO;
        cur_byte   = '0;
        cur_len    = '0;
        cur_last   = 1'b0;
        redraw_end = 1'b0;
        case (state_reg)
            SQ_RCR:
            begin
                cur_byte = CH_CR;
            end
            SQ_PROMPT:
            begin
                cur_byte   = prompt_char(step_reg);
                redraw_end = (step_reg == PROMPT_LAST) && (job_reg.fill == '0);
            end
            SQ_LINE:
            begin
                cur_byte   = rd_data;
                redraw_end = (LEN_W'(idx_reg) + LEN_W'(1)) == job_reg.fill;
            end
            SQ_ACT:
            begin
                case (job_reg.act)
                    ACT_COMMIT:
                    begin
                        if (step_reg == '0)
                        begin
                            cur_byte = CH_CR;
                        end
                        else
                        begin
                            cur_kind = KIND_READY;
                            cur_len  = job_reg.fill + LEN_W'(1);
                            cur_last = 1'b1;
                        end
                    end
                    ACT_EMPTY:
                    begin
                        cur_byte = (step_reg == '0) ? CH_LF : prompt_char(step_reg - 3'd1);
                        cur_last = (step_reg == PROMPT_LAST + 3'd1);
                    end
                    ACT_ERASE:
                    begin
                        case (step_reg)
                            3'd0:    cur_byte = CH_BS;
                            3'd1:    cur_byte = CH_ESC;
                            3'd2:    cur_byte = CH_LBRACK;
                            default: cur_byte = CH_K;
                        endcase
                        cur_last = (step_reg == 3'd3);
                    end
                    ACT_PRINT:
                    begin
                        cur_byte = job_reg.chr;
                        cur_last = 1'b1;
                    end
                    ACT_READ:
                    begin
                        cur_kind = job_reg.rd_empty ? KIND_EMPTY : KIND_DATA;
                        cur_byte = job_reg.rd_empty ? '0 : rd_data;
                        cur_last = 1'b1;
                    end
                    default:
                    begin
                        cur_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                cur_last = 1'b0;
            end
        endcase
        if (redraw_end && (job_reg.act == ACT_NONE))
        begin
            cur_last = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            case (state_reg)
                SQ_RCR:
                begin
                    state_next = SQ_PROMPT;
                    step_next  = '0;
                end
                SQ_PROMPT:
                begin
                    if (step_reg == PROMPT_LAST)
                    begin
                        state_next = redraw_end ? act_entry : SQ_LINE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
                SQ_LINE:
                begin
                    if (redraw_end)
                    begin
                        state_next = act_entry;
                        step_next  = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                SQ_ACT:
                begin
                    if (cur_last)
                    begin
                        state_next = SQ_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_next = SQ_IDLE;
                end
            endcase
        end
        if (start)
        begin
            step_next = '0;
            idx_next  = '0;
            if (job.redraw)
            begin
                state_next = SQ_RCR;
            end
            else
            begin
                state_next = (job.act == ACT_NONE) ? SQ_IDLE : SQ_ACT;
            end
        end
    end

    // address for the word needed next cycle
    assign rd_base = job_reg.sel ? AW'(LINE_DEPTH) : '0;
    assign rd_addr = rd_base + ((job_reg.act == ACT_READ) ? AW'(job_reg.rd_idx)
                                                          : AW'(idx_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            kind_reg  <= cur_kind;
            byte_reg  <= cur_byte;
            len_reg   <= cur_len;
            trace_reg <= trace;
            last_reg  <= cur_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.byte_out    = byte_reg;
    assign result.line_length = len_reg;
    assign result.trace_on    = trace_reg;
    assign result.last        = last_reg;

endmodule

// ----- tb/terminal_line_editor_tb.sv -----
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// Feeds received bytes, disturb notices, ready-line reads and unused opcodes
// to the line editor under random stalls on both channels. A local model of
// the editor predicts every echo, ready notice and read word. Each result
// word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module terminal_line_editor_tb;
    import tle_pkg::*;

    localparam int DEPTH          = LINE_DEPTH_DEF;
    localparam int STALL_PCT      = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;
    localparam int ITEM_TARGET    = 310;
    localparam int MAX_PRINTED    = 40;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [47:0]     PROMPT_TEXT = "CLI > ";

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] byte_out;
        logic [LEN_W-1:0]  line_length;
        logic              trace_on;
        logic              last;
    } tty_word_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_in;
        logic [IDX_W-1:0]  read_index;
        logic              hold_for_drain;
    } key_item_t;

    logic clk;
    logic rst_n;

    tle_in_if  item_ch ();
    tle_out_if result_ch ();

    terminal_line_editor #(
        .LINE_DEPTH(DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // editor model state
    logic [CHAR_W-1:0] line_mem [2*DEPTH];
    logic [LEN_W-1:0]  line_fill [2];
    logic              edit_buf;
    logic              line_ready;
    logic              redraw_due;
    logic              trace_en;

    key_item_t key_q [$];
    tty_word_t tty_q [$];
    tty_word_t burst [$];
    key_item_t next_key;
    tty_word_t oldest;

    logic drained;
    int   cycle_cnt = 0;
    int   stall_cnt = 0;
    int   err_cnt = 0;
    int   words_checked = 0;
    int   key_total = 0;
    int   lines_committed = 0;
    int   forced_commits = 0;
    int   redraws = 0;

    wire quiet = (cycle_cnt >= 600) && (cycle_cnt < 1100);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED)
            $display("mismatch on %0s at word %0d: expected %0h, got %0h",
                     what, words_checked, want_v, got_v);
    endtask

    function automatic void emit(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] b,
                                 input logic [LEN_W-1:0] len);
        tty_word_t w;
        w.kind        = kind;
        w.byte_out    = b;
        w.line_length = len;
        w.trace_on    = 1'b0;
        w.last        = 1'b0;
        burst.push_back(w);
    endfunction

    function automatic void emit_prompt();
        int i;
        for (i = 0; i < 6; i++)
            emit(KIND_ECHO, PROMPT_TEXT[47-8*i -: 8], '0);
    endfunction

    // Applies one word to the editor model and queues the words it produces.
    function automatic void edit_line(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch_in,
                                      input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        int                b;
        int                n;
        int                rb;
        int                i;
        tty_word_t         w;
        burst.delete();
        ch = ch_in;
        b  = int'(edit_buf);
        n  = int'(line_fill[b]);
        if (op == OP_CHAR)
        begin
            if (redraw_due && ch != CH_CR)
            begin
                emit(KIND_ECHO, CH_CR, '0);
                emit_prompt();
                for (i = 0; i < n; i++)
                    emit(KIND_ECHO, line_mem[b*DEPTH+i], '0);
                redraw_due = 1'b0;
                redraws++;
            end
            // full line: byte becomes Enter
            if (n >= DEPTH-1)
            begin
                ch = CH_CR;
                forced_commits++;
            end
            if (ch == CH_CR)
            begin
                if (n > 0)
                begin
                    line_mem[b*DEPTH+n] = CH_LF;
                    n++;
                    line_fill[b] = LEN_W'(n);
                    emit(KIND_ECHO, CH_CR, '0);
                    line_ready = 1'b1;
                    emit(KIND_READY, '0, LEN_W'(n));
                    edit_buf = ~edit_buf;
                    line_fill[b^1] = '0;
                    lines_committed++;
                end
                else
                begin
                    emit(KIND_ECHO, CH_LF, '0);
                    emit_prompt();
                end
            end
            else if (ch == CH_XOFF)
                trace_en = 1'b0;
            else if (ch == CH_XON)
                trace_en = 1'b1;
            else if (ch == CH_BS || ch == CH_DEL)
            begin
                if (n > 0)
                    line_fill[b] = LEN_W'(n - 1);
                emit(KIND_ECHO, CH_BS, '0);
                emit(KIND_ECHO, CH_ESC, '0);
                emit(KIND_ECHO, CH_LBRACK, '0);
                emit(KIND_ECHO, CH_K, '0);
            end
            else if (ch >= CH_SPACE && ch <= CH_TILDE)
            begin
                line_mem[b*DEPTH+n] = ch;
                line_fill[b] = LEN_W'(n + 1);
                emit(KIND_ECHO, ch, '0);
            end
            // ESC and other non-printables are dropped
        end
        else if (op == OP_DISTURB)
            redraw_due = 1'b1;
        else if (op == OP_READ)
        begin
            rb = b ^ 1;
            if (!line_ready || idx >= line_fill[rb])
                emit(KIND_EMPTY, '0, '0);
            else
                emit(KIND_DATA, line_mem[rb*DEPTH+idx], '0);
        end
        for (i = 0; i < burst.size(); i++)
        begin
            w          = burst[i];
            w.trace_on = trace_en;
            w.last     = (i == burst.size() - 1);
            tty_q.push_back(w);
        end
    endfunction

    task automatic add_key(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input bit hold);
        key_item_t k;
        k.operation      = op;
        k.char_in        = ch;
        k.read_index     = idx;
        k.hold_for_drain = hold;
        key_q.push_back(k);
        if (op != OP_UNUSED)
            key_total++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.operation  <= OP_CHAR;
            item_ch.char_in    <= '0;
            item_ch.read_index <= '0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (key_q.size() != 0 && (quiet || $urandom_range(99) >= STALL_PCT)
                && (!key_q[0].hold_for_drain || (!item_ch.valid && drained)))
            begin
                next_key = key_q.pop_front();
                item_ch.operation  <= next_key.operation;
                item_ch.char_in    <= next_key.char_in;
                item_ch.read_index <= next_key.read_index;
                item_ch.valid      <= 1'b1;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // monitor: predicts on accepted items, checks accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            drained         <= 1'b1;
            for (int j = 0; j < 2*DEPTH; j++)
                line_mem[j] = '0;
            line_fill[0] = '0;
            line_fill[1] = '0;
            edit_buf     = 1'b0;
            line_ready   = 1'b0;
            redraw_due   = 1'b1;
            trace_en     = 1'b1;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                edit_line(item_ch.operation, item_ch.char_in, item_ch.read_index);
            if (result_ch.valid && result_ch.ready)
            begin
                if (tty_q.size() == 0)
                    report_mismatch("word with none expected", 0, int'(result_ch.byte_out));
                else
                begin
                    oldest = tty_q.pop_front();
                    if (result_ch.kind !== oldest.kind)
                        report_mismatch("kind", int'(oldest.kind), int'(result_ch.kind));
                    if (result_ch.byte_out !== oldest.byte_out)
                        report_mismatch("byte_out", int'(oldest.byte_out),
                                        int'(result_ch.byte_out));
                    if (result_ch.line_length !== oldest.line_length)
                        report_mismatch("line_length", int'(oldest.line_length),
                                        int'(result_ch.line_length));
                    if (result_ch.trace_on !== oldest.trace_on)
                        report_mismatch("trace_on", int'(oldest.trace_on),
                                        int'(result_ch.trace_on));
                    if (result_ch.last !== oldest.last)
                        report_mismatch("last", int'(oldest.last), int'(result_ch.last));
                end
                words_checked++;
            end
            result_ch.ready <= quiet || ($urandom_range(99) >= STALL_PCT);
            drained         <= (tty_q.size() == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt <= cycle_cnt + 1;
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cnt <= 0;
            else if (stall_cnt >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                         stall_cnt, tty_q.size());
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    initial
    begin
        int                j;
        int                r;
        int                line_len;
        int                pick;
        bit                hold;
        logic [CHAR_W-1:0] ch;

        rst_n = 1'b0;

        // directed
        add_key(OP_READ,   8'h00,   5'd0,  1'b0);  // nothing ready yet
        add_key(OP_UNUSED, 8'hFF,   5'd31, 1'b0);
        add_key(OP_CHAR,   CH_CR,   5'd0,  1'b0);  // empty Enter, redraw stays due
        add_key(OP_CHAR,   8'h41,   5'd0,  1'b0);  // redraw then echo
        add_key(OP_CHAR,   CH_SPACE, 5'd0, 1'b0);
        add_key(OP_CHAR,   CH_TILDE, 5'd0, 1'b0);
        add_key(OP_CHAR,   CH_DEL,  5'd0,  1'b0);
        add_key(OP_CHAR,   CH_BS,   5'd0,  1'b0);
        add_key(OP_CHAR,   CH_BS,   5'd0,  1'b0);
        add_key(OP_CHAR,   CH_BS,   5'd0,  1'b0);  // erase on empty line
        add_key(OP_CHAR,   CH_ESC,  5'd0,  1'b0);
        add_key(OP_CHAR,   8'h00,   5'd0,  1'b0);
        add_key(OP_CHAR,   8'h80,   5'd0,  1'b0);
        add_key(OP_CHAR,   8'hFF,   5'd0,  1'b0);
        add_key(OP_CHAR,   8'h1F,   5'd0,  1'b0);
        add_key(OP_CHAR,   CH_XOFF, 5'd0,  1'b0);
        add_key(OP_CHAR,   8'h7A,   5'd0,  1'b0);
        add_key(OP_CHAR,   CH_XON,  5'd0,  1'b0);
        add_key(OP_DISTURB, 8'h00,  5'd0,  1'b0);
        add_key(OP_CHAR,   8'h71,   5'd0,  1'b0);  // redraw with pending text
        add_key(OP_CHAR,   CH_CR,   5'd0,  1'b0);  // commit
        add_key(OP_READ,   8'h00,   5'd0,  1'b1);  // sender waits for all words
        add_key(OP_READ,   8'h00,   5'd2,  1'b0);
        add_key(OP_READ,   8'h00,   5'd31, 1'b0);
        add_key(OP_CHAR,   CH_CR,   5'd0,  1'b0);

        // random: mostly edited lines, some noise
        while (key_total < ITEM_TARGET)
        begin
            hold = ($urandom_range(99) < 4);
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    add_key(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                            IDX_W'($urandom_range(0, 31)), hold);
                    hold = 1'b0;
                end
            end
            else
            begin
                if ($urandom_range(99) < 20)
                begin
                    add_key(OP_DISTURB, CHAR_W'($urandom_range(0, 255)),
                            IDX_W'($urandom_range(0, 31)), hold);
                    hold = 1'b0;
                end
                line_len = ($urandom_range(99) < 12) ? $urandom_range(32, 40)
                                                     : $urandom_range(0, 10);
                for (j = 0; j < line_len; j++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        ch = $urandom_range(1) ? CH_BS : CH_DEL;
                    else if (pick < 11)
                        ch = $urandom_range(1) ? CH_XOFF : CH_XON;
                    else if (pick < 14)
                        ch = CHAR_W'($urandom_range(1) ? $urandom_range(128, 255)
                                                       : $urandom_range(0, 31));
                    else
                        ch = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
                    if (pick >= 96)
                        add_key(OP_DISTURB, CHAR_W'($urandom_range(0, 255)),
                                IDX_W'($urandom_range(0, 31)), 1'b0);
                    add_key(OP_CHAR, ch, IDX_W'($urandom_range(0, 31)), hold);
                    hold = 1'b0;
                end
                if ($urandom_range(99) < 85)
                    add_key(OP_CHAR, CH_CR, IDX_W'($urandom_range(0, 31)), hold);
                for (r = $urandom_range(0, 4); r > 0; r--)
                    add_key(OP_READ, CHAR_W'($urandom_range(0, 255)),
                            IDX_W'(($urandom_range(99) < 75) ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 31)),
                            1'b0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (key_q.size() != 0 || item_ch.valid || tty_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tty_q.size() != 0)
            report_mismatch("words never produced", tty_q.size(), 0);

        $display("covered %0d input words, %0d result words checked, %0d redraws",
                 key_total, words_checked, redraws);
        $display("%0d lines committed (%0d at full length), %0d mismatches",
                 lines_committed, forced_commits, err_cnt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
